FILE: src/tts_pkg.sv
// shared types and constants for the tlv type search block
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package tts_pkg;

	// width of the byte position and record start counters
	localparam int SIZE_BITS = 16;

	// field widths
	localparam int TYPE_W   = 16;
	localparam int LEN_W    = 16;
	localparam int STATUS_W = 2;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	// record header is four bytes long
	localparam logic [LEN_W-1:0] HDR_LEN = LEN_W'(4);

	// header byte phases
	localparam logic [1:0] HDR_TYPE_LO = 2'd0;
	localparam logic [1:0] HDR_TYPE_HI = 2'd1;
	localparam logic [1:0] HDR_LEN_LO  = 2'd2;
	localparam logic [1:0] HDR_LEN_HI  = 2'd3;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_CORRUPT   = 2'd2;
	localparam logic [STATUS_W-1:0] ST_UNHANDLED = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_WANTED_TYPE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_KNOWN_FIRST  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KNOWN_SECOND = 2'd2;

	// configuration reset values
	localparam logic [TYPE_W-1:0] WANTED_RST       = 16'd0;
	localparam logic [TYPE_W-1:0] KNOWN_FIRST_RST  = 16'd275;
	localparam logic [TYPE_W-1:0] KNOWN_SECOND_RST = 16'd298;

	typedef struct packed {
		logic [TYPE_W-1:0] wanted_type;
		logic [TYPE_W-1:0] known_type_first;
		logic [TYPE_W-1:0] known_type_second;
	} tts_cfg_t;

	typedef struct packed {
		logic [7:0]       data_byte;
		logic             first_byte;
		logic             last_byte;
		logic [LEN_W-1:0] buffer_size;
	} tts_beat_t;

	typedef struct packed {
		logic [LEN_W-1:0]     bytes_left;
		logic [1:0]           header_index;
		logic [TYPE_W-1:0]    type_shift;
		logic [LEN_W-1:0]     length_shift;
		logic [LEN_W-1:0]     skip_count;
		logic [SIZE_BITS-1:0] record_start;
		logic [SIZE_BITS-1:0] byte_position;
		logic                 search_done;
	} tts_state_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [15:0]         record_offset;
		logic [LEN_W-1:0]    value_length;
	} tts_result_t;

endpackage

FILE: src/tts_cfg_regs.sv
// configuration registers of the tlv type search block
// depends on tts_pkg for register indexes, reset values and the config struct
`timescale 1ns / 1ps

module tts_cfg_regs (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [tts_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tts_pkg::CFG_DATA_W-1:0] cfg_data,
	output tts_pkg::tts_cfg_t             cfg
);
	import tts_pkg::*;

	tts_cfg_t cfg_q;

	// writes are always taken
	assign cfg_ready = 1'b1;

	// register file, unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wanted_type       <= WANTED_RST;
			cfg_q.known_type_first  <= KNOWN_FIRST_RST;
			cfg_q.known_type_second <= KNOWN_SECOND_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_WANTED_TYPE:  cfg_q.wanted_type       <= cfg_data;
				CFG_KNOWN_FIRST:  cfg_q.known_type_first  <= cfg_data;
				CFG_KNOWN_SECOND: cfg_q.known_type_second <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: src/tts_scan.sv
// per-byte search step and search state register
// depends on tts_pkg for the beat, state, config and result types
`timescale 1ns / 1ps

module tts_scan (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step_en,
	input  tts_pkg::tts_beat_t    beat,
	input  tts_pkg::tts_cfg_t     cfg,
	output logic                  emit,
	output tts_pkg::tts_result_t  result,
	output logic                  search_done
);
	import tts_pkg::*;

	tts_state_t state_q;
	tts_state_t cur;
	tts_state_t nxt;
	logic [LEN_W-1:0] len_new;
	logic [LEN_W:0]   need;
	logic [LEN_W-1:0] left_new;

	// next state and result for the byte in the input stage
	always_comb begin
		cur      = state_q;
		len_new  = {beat.data_byte, state_q.length_shift[7:0]};
		need     = {1'b0, HDR_LEN} + {1'b0, len_new};
		left_new = state_q.bytes_left - need[LEN_W-1:0];
		emit     = 1'b0;
		result   = '0;

		// first byte restarts the search
		if (beat.first_byte) begin
			cur              = '0;
			cur.bytes_left   = beat.buffer_size;
			cur.search_done  = 1'b0;
			left_new         = beat.buffer_size - need[LEN_W-1:0];
		end
		nxt = cur;

		if (beat.first_byte && (beat.buffer_size < HDR_LEN)) begin
			// buffer too short for any header
			emit          = 1'b1;
			result.status = ST_NOT_FOUND;
		end else if (!cur.search_done) begin
			nxt.byte_position = cur.byte_position + SIZE_BITS'(1);
			if (cur.skip_count != '0) begin
				// skipping value bytes
				nxt.skip_count = cur.skip_count - LEN_W'(1);
				if ((nxt.skip_count == '0) && (cur.bytes_left < HDR_LEN)) begin
					emit          = 1'b1;
					result.status = ST_NOT_FOUND;
				end
			end else begin
				// collecting header bytes
				nxt.header_index = cur.header_index + 2'd1;
				case (cur.header_index)
					HDR_TYPE_LO: begin
						nxt.record_start = cur.byte_position;
						nxt.type_shift   = {8'd0, beat.data_byte};
					end
					HDR_TYPE_HI: nxt.type_shift = {beat.data_byte, cur.type_shift[7:0]};
					HDR_LEN_LO:  nxt.length_shift = {8'd0, beat.data_byte};
					HDR_LEN_HI: begin
						nxt.length_shift = len_new;
						if (need > {1'b0, cur.bytes_left}) begin
							emit          = 1'b1;
							result.status = ST_CORRUPT;
						end else if (cur.type_shift == cfg.wanted_type) begin
							emit = 1'b1;
							if ((cur.type_shift == cfg.known_type_first) ||
							    (cur.type_shift == cfg.known_type_second)) begin
								result.status        = ST_FOUND;
								result.record_offset = 16'(cur.record_start);
								result.value_length  = len_new;
							end else begin
								result.status = ST_UNHANDLED;
							end
						end else begin
							nxt.bytes_left = left_new;
							nxt.skip_count = len_new;
							if ((len_new == '0) && (left_new < HDR_LEN)) begin
								emit          = 1'b1;
								result.status = ST_NOT_FOUND;
							end
						end
					end
					default: ;
				endcase
			end
			// early end of buffer
			if (!emit && beat.last_byte) begin
				emit          = 1'b1;
				result.status = ST_NOT_FOUND;
			end
		end

		if (emit) begin
			nxt.search_done = 1'b1;
		end
	end

	// search state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q             <= '0;
			state_q.search_done <= 1'b1;
		end else if (step_en) begin
			state_q <= nxt;
		end
	end

	assign search_done = state_q.search_done;

endmodule

FILE: src/tlv_type_search_core.sv
// top level of the tlv type search block: input stage, search step, result register
// depends on tts_pkg, tts_cfg_regs and tts_scan
`timescale 1ns / 1ps

// Usage
// Buffer bytes enter on the byte channel (byte_valid/byte_stall), one byte per
// beat, with first_byte on offset 0 and buffer_size sampled with it. At most
// one result per buffer leaves on the result channel (result_valid/
// result_stall): status, record_offset and value_length.
// Each byte is taken into an input register, and the search step between that
// register and the result register handles it, so one byte a cycle is taken
// when the receiver keeps up. A result is written into the result register when
// the step handles the byte in the input register that causes it.
// When the result register holds an untaken result, the step pauses; the input
// register still takes one byte, then byte_stall rises until the result goes.
// Configuration is written through cfg_valid/cfg_ready (always ready), index
// 0 wanted type, 1 and 2 the known types; write only while the block is idle.
// Reset leaves the search idle: bytes are ignored until a first byte arrives,
// and the configuration returns to its reset values.

module tlv_type_search_core (
	input  logic                           clk,
	input  logic                           arst_n,
	// byte channel
	input  logic                           byte_valid,
	output logic                           byte_stall,
	input  logic [7:0]                     data_byte,
	input  logic                           first_byte,
	input  logic                           last_byte,
	input  logic [tts_pkg::LEN_W-1:0]      buffer_size,
	// result channel
	output logic                           result_valid,
	input  logic                           result_stall,
	output logic [tts_pkg::STATUS_W-1:0]   status,
	output logic [15:0]                    record_offset,
	output logic [tts_pkg::LEN_W-1:0]      value_length,
	// configuration channel
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [tts_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tts_pkg::CFG_DATA_W-1:0] cfg_data
);
	import tts_pkg::*;

	tts_cfg_t    cfg;
	tts_beat_t   beat_s1;
	logic        valid_s1;
	logic        advance;
	logic        emit;
	tts_result_t result;
	tts_result_t result_q;
	logic        result_valid_q;
	logic        search_done;

	// configuration registers
	tts_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// the step runs when the result register is free or being emptied
	assign advance    = valid_s1 && (!result_valid_q || !result_stall);
	assign byte_stall = valid_s1 && !advance;

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!byte_stall) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_valid && !byte_stall) begin
			beat_s1.data_byte   <= data_byte;
			beat_s1.first_byte  <= first_byte;
			beat_s1.last_byte   <= last_byte;
			beat_s1.buffer_size <= buffer_size;
		end
	end

	// search step and state
	tts_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (advance),
		.beat        (beat_s1),
		.cfg         (cfg),
		.emit        (emit),
		.result      (result),
		.search_done (search_done)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= emit;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			result_q <= result;
		end
	end

	assign result_valid  = result_valid_q;
	assign status        = result_q.status;
	assign record_offset = result_q.record_offset;
	assign value_length  = result_q.value_length;

	// input only stalls behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		byte_stall |-> (valid_s1 && result_valid_q && result_stall))
		else $error("byte stall without a held result");

	// any result closes the search
	a_done_after_result: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit) |=> search_done)
		else $error("search still open after a result");

	// offset and length are zero unless found
	a_zero_unless_found: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && (result_q.status != ST_FOUND)) |->
		((result_q.record_offset == '0) && (result_q.value_length == '0)))
		else $error("nonzero offset or length on a non-found result");

	// a finished search gives no further result without a new buffer
	a_no_result_when_done: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && search_done && !beat_s1.first_byte) |-> !emit)
		else $error("result from a finished search");

endmodule

FILE: bench/tlv_type_search_core_test.sv
// self-checking bench for tlv_type_search_core: buffers of tlv records in, search outcomes out
// depends on tts_pkg and the block's rtl; predicts each outcome and compares it per field
`timescale 1ns / 1ps

module tlv_type_search_core_test;
	import tts_pkg::*;

	localparam int CYCLE_LIMIT  = 1000000;
	localparam int SETTLE_CYCLES = 6;
	localparam int HOLD_CYCLES  = 300;
	localparam int MAX_FRAME    = 40;
	localparam int PHASE_BEATS  = 100;

	logic                  clk;
	logic                  arst_n = 1'b0;
	logic                  byte_valid = 1'b0;
	logic                  byte_stall;
	logic [7:0]            data_byte;
	logic                  first_byte;
	logic                  last_byte;
	logic [LEN_W-1:0]      buffer_size;
	logic                  result_valid;
	logic                  result_stall = 1'b0;
	logic [STATUS_W-1:0]   status;
	logic [15:0]           record_offset;
	logic [LEN_W-1:0]      value_length;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// beat on the byte channel
	tts_beat_t cur_beat = '0;
	assign data_byte   = cur_beat.data_byte;
	assign first_byte  = cur_beat.first_byte;
	assign last_byte   = cur_beat.last_byte;
	assign buffer_size = cur_beat.buffer_size;

	tlv_type_search_core i_dut (.*);

	// stimulus and outcome stores
	tts_beat_t   byte_backlog[$];
	tts_result_t awaited_results[$];
	logic [7:0]  frame[$];
	int          beats_queued = 0;
	int          beats_taken = 0;
	int          phase_beats = 0;
	int          error_count = 0;
	int          cycle_count = 0;
	int          send_idle_pct = 0;
	int          stall_pct = 0;
	logic        hold_go = 1'b0;
	logic        hold_done = 1'b0;
	int          hold_left = 0;

	// search state of the predictor
	logic [TYPE_W-1:0]    want_type = WANTED_RST;
	logic [TYPE_W-1:0]    known_a = KNOWN_FIRST_RST;
	logic [TYPE_W-1:0]    known_b = KNOWN_SECOND_RST;
	logic [LEN_W-1:0]     scan_left = '0;
	logic [1:0]           hdr_phase = HDR_TYPE_LO;
	logic [TYPE_W-1:0]    type_acc = '0;
	logic [LEN_W-1:0]     len_acc = '0;
	logic [LEN_W-1:0]     skip_left = '0;
	logic [SIZE_BITS-1:0] rec_start = '0;
	logic [SIZE_BITS-1:0] byte_pos = '0;
	logic                 scan_done = 1'b1;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// a search ends with exactly one outcome
	function automatic bit close_search(input logic [STATUS_W-1:0] st, input logic [15:0] off,
			input logic [LEN_W-1:0] len, output tts_result_t r);
		r.status = st;
		r.record_offset = off;
		r.value_length = len;
		scan_done = 1'b1;
		return 1'b1;
	endfunction

	// advance the search by one byte; returns 1 when the byte ends the search
	function automatic bit scan_byte(input tts_beat_t b, output tts_result_t r);
		logic [LEN_W:0] need;
		r = '0;
		if (b.first_byte) begin
			scan_left = b.buffer_size;
			hdr_phase = HDR_TYPE_LO;
			type_acc = '0;
			len_acc = '0;
			skip_left = '0;
			rec_start = '0;
			byte_pos = '0;
			scan_done = 1'b0;
			if (scan_left < HDR_LEN)
				return close_search(ST_NOT_FOUND, '0, '0, r);
		end
		if (scan_done)
			return 1'b0;
		if (skip_left != '0) begin
			// inside a record value that is skipped
			skip_left = skip_left - LEN_W'(1);
			byte_pos = byte_pos + SIZE_BITS'(1);
			if (skip_left == '0 && scan_left < HDR_LEN)
				return close_search(ST_NOT_FOUND, '0, '0, r);
		end else begin
			// collect the header, little-endian type then length
			case (hdr_phase)
				HDR_TYPE_LO: begin
					rec_start = byte_pos;
					type_acc = {8'h00, b.data_byte};
				end
				HDR_TYPE_HI: type_acc = type_acc | {b.data_byte, 8'h00};
				HDR_LEN_LO: len_acc = {8'h00, b.data_byte};
				default: len_acc = len_acc | {b.data_byte, 8'h00};
			endcase
			byte_pos = byte_pos + SIZE_BITS'(1);
			if (hdr_phase != HDR_LEN_HI) begin
				hdr_phase = hdr_phase + 2'd1;
			end else begin
				need = {1'b0, HDR_LEN} + {1'b0, len_acc};
				hdr_phase = HDR_TYPE_LO;
				if (need > {1'b0, scan_left})
					return close_search(ST_CORRUPT, '0, '0, r);
				if (type_acc == want_type) begin
					if (type_acc == known_a || type_acc == known_b)
						return close_search(ST_FOUND, 16'(rec_start), len_acc, r);
					return close_search(ST_UNHANDLED, '0, '0, r);
				end
				scan_left = scan_left - need[LEN_W-1:0];
				skip_left = len_acc;
				if (skip_left == '0 && scan_left < HDR_LEN)
					return close_search(ST_NOT_FOUND, '0, '0, r);
			end
		end
		if (b.last_byte)
			return close_search(ST_NOT_FOUND, '0, '0, r);
		return 1'b0;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t mismatch %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
		error_count++;
	endtask

	// byte driver: predict each taken beat, then offer the next one
	always @(posedge clk) begin : feed_bytes
		tts_result_t outcome;
		if (arst_n) begin
			if (byte_valid && !byte_stall) begin
				if (scan_byte(cur_beat, outcome))
					awaited_results.push_back(outcome);
				beats_taken++;
			end
			if (!byte_valid || !byte_stall) begin
				if (byte_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					cur_beat <= byte_backlog.pop_front();
					byte_valid <= 1'b1;
				end else begin
					byte_valid <= 1'b0;
				end
			end
		end
	end

	// result receiver: random stall, plus one long hold-off
	always @(posedge clk) begin : take_results
		if (arst_n) begin
			if (hold_left != 0) begin
				result_stall <= 1'b1;
				hold_left <= hold_left - 1;
			end else if (hold_go && !hold_done && result_valid) begin
				result_stall <= 1'b1;
				hold_left <= HOLD_CYCLES;
				hold_done <= 1'b1;
			end else begin
				result_stall <= ($urandom_range(99) < stall_pct);
			end
		end
	end

	// compare each taken result beat with the oldest expectation
	always @(posedge clk) begin : check_results
		tts_result_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (awaited_results.size() == 0) begin
				report_mismatch("result with none awaited, status", int'(status), 0);
			end else begin
				want = awaited_results.pop_front();
				if (status !== want.status)
					report_mismatch("status", int'(status), int'(want.status));
				if (record_offset !== want.record_offset)
					report_mismatch("record_offset", int'(record_offset),
						int'(want.record_offset));
				if (value_length !== want.value_length)
					report_mismatch("value_length", int'(value_length),
						int'(want.value_length));
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic push_beat(input logic [7:0] data, input logic first, input logic last,
			input logic [LEN_W-1:0] size, input bit counted);
		tts_beat_t b;
		b.data_byte = data;
		b.first_byte = first;
		b.last_byte = last;
		b.buffer_size = size;
		byte_backlog.push_back(b);
		beats_queued++;
		if (counted)
			phase_beats++;
	endtask

	task automatic add_header(input logic [TYPE_W-1:0] rtype, input logic [LEN_W-1:0] rlen);
		frame.push_back(rtype[7:0]);
		frame.push_back(rtype[15:8]);
		frame.push_back(rlen[7:0]);
		frame.push_back(rlen[15:8]);
	endtask

	// queue the first cut bytes of the frame as one buffer
	task automatic send_frame(input logic [LEN_W-1:0] size, input int cut, input bit mark_end);
		for (int i = 0; i < cut; i++)
			push_beat(frame[i], i == 0, mark_end && i == cut - 1,
				(i == 0) ? size : LEN_W'($urandom), 1'b1);
		frame.delete();
	endtask

	// one random buffer: mostly well-formed records, some noise and broken ones
	task automatic queue_buffer();
		int kind;
		int pick;
		int cut;
		int n;
		bit no_last;
		logic [LEN_W-1:0] size;
		logic [TYPE_W-1:0] rtype;
		logic [LEN_W-1:0] rlen;
		kind = $urandom_range(99);
		if (kind < 8) begin
			// stray beats while no search runs
			repeat ($urandom_range(1, 3))
				push_beat(8'($urandom), 1'b0, 1'($urandom), LEN_W'($urandom), 1'b0);
		end else if (kind < 14) begin
			// buffer too short for a header
			push_beat(8'($urandom), 1'b1, 1'($urandom), LEN_W'($urandom_range(3)), 1'b1);
		end else if (kind < 24) begin
			// random bytes and size
			n = $urandom_range(1, 16);
			for (int i = 0; i < n; i++)
				frame.push_back(8'($urandom));
			send_frame(LEN_W'($urandom), n, 1'b1);
		end else begin
			n = $urandom_range(0, 4);
			for (int k = 0; k < n && frame.size() < MAX_FRAME; k++) begin
				pick = $urandom_range(99);
				if (pick < 35)
					rtype = TYPE_W'($urandom);
				else if (pick < 60)
					rtype = want_type;
				else if (pick < 80)
					rtype = known_a;
				else
					rtype = known_b;
				rlen = ($urandom_range(19) == 0) ? LEN_W'($urandom) : LEN_W'($urandom_range(5));
				add_header(rtype, rlen);
				for (int j = 0; j < rlen && frame.size() < MAX_FRAME; j++)
					frame.push_back(8'($urandom));
			end
			repeat ($urandom_range(3))
				frame.push_back(8'($urandom));
			if (frame.size() == 0)
				frame.push_back(8'($urandom));
			pick = $urandom_range(99);
			if (pick < 70)
				size = LEN_W'(frame.size());
			else if (pick < 85)
				size = LEN_W'(frame.size() + $urandom_range(4) - 2);
			else
				size = LEN_W'($urandom);
			cut = frame.size();
			if ($urandom_range(9) == 0)
				cut = $urandom_range(1, frame.size());
			no_last = ($urandom_range(14) == 0);
			send_frame(size, cut, !no_last);
			if ($urandom_range(7) == 0)
				repeat ($urandom_range(1, 3))
					push_beat(8'($urandom), 1'b0, 1'($urandom), LEN_W'($urandom), 1'b0);
		end
	endtask

	// a match far into a full-size buffer, after one long skipped record
	task automatic queue_long_match(input logic [15:0] offset);
		add_header(~want_type, offset - 16'd4);
		repeat (offset - 16'd4)
			frame.push_back(8'($urandom));
		add_header(want_type, LEN_W'($urandom_range(0, 32'hFFFF - offset - 4)));
		send_frame(16'hFFFF, frame.size(), 1'b1);
	endtask

	// wait until every beat is taken and every outcome has come, then let the block settle
	task automatic wait_drained();
		do @(posedge clk);
		while (beats_taken != beats_queued || awaited_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_WANTED_TYPE: want_type = val;
			CFG_KNOWN_FIRST: known_a = val;
			CFG_KNOWN_SECOND: known_b = val;
			default: ;
		endcase
	endtask

	initial begin : run_test
		logic [TYPE_W-1:0] w;
		logic [TYPE_W-1:0] ka;
		logic [TYPE_W-1:0] kb;
		int pick;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// stray beat while idle, then buffers shorter than a header
		push_beat(8'h00, 1'b0, 1'b1, 16'hFFFF, 1'b0);
		push_beat(8'hFF, 1'b1, 1'b1, 16'h0000, 1'b1);
		push_beat(8'h5A, 1'b1, 1'b0, 16'h0003, 1'b1);
		// wanted type matches but is not a known type
		add_header(16'h0000, 16'h0000);
		send_frame(16'd4, 4, 1'b0);
		// length overruns the buffer, outcome wins over last byte
		add_header(16'hFFFF, 16'hFFFF);
		send_frame(16'hFFFF, 4, 1'b1);
		// fewer than a header left after a record, excess byte ignored
		add_header(16'h0009, 16'h0000);
		send_frame(16'd6, 4, 1'b0);
		push_beat(8'h33, 1'b0, 1'b0, 16'd6, 1'b0);
		// buffer ends inside a record value
		add_header(16'h0009, 16'h0002);
		frame.push_back(8'hC3);
		send_frame(16'd20, 5, 1'b1);
		wait_drained();
		// plain match on a known type
		write_reg(CFG_WANTED_TYPE, KNOWN_FIRST_RST);
		add_header(KNOWN_FIRST_RST, 16'd4);
		send_frame(16'd8, 4, 1'b0);
		wait_drained();

		// random phases: sender idles lightly, then heavily, then not at all
		for (int p = 0; p < 9; p++) begin
			send_idle_pct <= (p < 3) ? 11 : (p < 6) ? 48 : 0;
			stall_pct <= (p < 3) ? 48 : (p < 6) ? 11 : 0;
			case (p)
				0: begin
					w = 16'h0000;
					ka = 16'h0000;
					kb = 16'hFFFF;
				end
				1: begin
					w = 16'hFFFF;
					ka = 16'h0000;
					kb = 16'hFFFF;
				end
				default: begin
					ka = TYPE_W'($urandom);
					kb = TYPE_W'($urandom);
					pick = $urandom_range(2);
					w = (pick == 0) ? ka : (pick == 1) ? kb : TYPE_W'($urandom);
				end
			endcase
			write_reg(CFG_WANTED_TYPE, w);
			write_reg(CFG_KNOWN_FIRST, ka);
			write_reg(CFG_KNOWN_SECOND, kb);
			phase_beats = 0;
			while (phase_beats < PHASE_BEATS)
				queue_buffer();
			if (p == 0)
				hold_go <= 1'b1;
			wait_drained();
		end

		// a match at a far offset reaches the upper byte of record_offset
		ka = TYPE_W'($urandom);
		write_reg(CFG_KNOWN_FIRST, ka);
		write_reg(CFG_WANTED_TYPE, ka);
		queue_long_match(16'h0100);
		wait_drained();

		if (error_count == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

FILE: tlv_type_search_core.f
src/tts_pkg.sv
src/tts_cfg_regs.sv
src/tts_scan.sv
src/tlv_type_search_core.sv
bench/tlv_type_search_core_test.sv
